// ----- rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared types, opcodes, status codes and defaults for the list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DEFAULT_CAPACITY   = 64;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // search scan examines 2**SCAN_GROUP_BITS cells per cycle
   localparam int SCAN_GROUP_BITS = 3;
   localparam int SCAN_GROUP      = 1 << SCAN_GROUP_BITS;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_POS   = 3'd1;
   localparam logic [2:0] STATUS_EMPTY     = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] found_position;
      logic [6:0] length;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic delete;
   } cell_cmd_type;

   typedef struct packed {
      logic done;
      logic hit;
   } scan_status_type;

endpackage

// ----- rtl/ple_cell.sv -----
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry; shifts from its left or right neighbor on insert or
// delete and compares its entry against the broadcast key.
// ----------------------------------------------------------------------------
module ple_cell #(
   parameter int DATA_WIDTH = ple_pkg::DEFAULT_DATA_WIDTH,
   parameter int CAPACITY   = ple_pkg::DEFAULT_CAPACITY,
   parameter int INDEX      = 0
) (
   input  logic                                clock,
   input  ple_pkg::cell_cmd_type               cmd,
   input  logic [$clog2(CAPACITY)-1:0]         idx,
   input  logic [$clog2(CAPACITY+1)-1:0]       count,
   input  logic [DATA_WIDTH-1:0]               key,
   input  logic [DATA_WIDTH-1:0]               left_data,
   input  logic [DATA_WIDTH-1:0]               right_data,
   output logic [DATA_WIDTH-1:0]               data,
   output logic                                match
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);
   localparam logic [IW-1:0] INDEX_I = IW'(INDEX);
   localparam logic [CW-1:0] INDEX_C = CW'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.insert) begin
         if (INDEX_I == idx) begin
            data_in = key;
         end else if (INDEX_I > idx) begin
            data_in = left_data;
         end
      end else if (cmd.delete) begin
         if (INDEX_I >= idx) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (INDEX_C < count) && (data_ff == key);

endmodule

// ----- rtl/ple_scan.sv -----
// ----------------------------------------------------------------------------
// First-match scanner
// Takes the cell match vector and finds the lowest matching position, one
// group of cells per cycle.
// ----------------------------------------------------------------------------
module ple_scan #(
   parameter int CAPACITY = ple_pkg::DEFAULT_CAPACITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [CAPACITY-1:0]               match_vector,
   output ple_pkg::scan_status_type          status,
   output logic [$clog2(CAPACITY+1)-1:0]     position
);

   localparam int CW  = $clog2(CAPACITY+1);
   localparam int GB  = ple_pkg::SCAN_GROUP_BITS;
   localparam int G   = ple_pkg::SCAN_GROUP;
   localparam int NG  = (CAPACITY + G - 1) / G;
   localparam int VW  = NG * G;
   localparam int GW  = $clog2(NG+1);
   localparam int PSW = GW + GB + 1;

   logic [VW-1:0]  vec_ff;
   logic [VW-1:0]  vec_in;
   logic [GW-1:0]  grp_ff;
   logic [GW-1:0]  grp_in;
   logic           active_ff;
   logic           active_in;
   logic [G-1:0]   low;
   logic [GB-1:0]  first_bit;
   logic           any;
   logic           last;
   logic [PSW-1:0] pos_full;

   always_comb begin
      low       = vec_ff[G-1:0];
      any       = |low;
      first_bit = '0;
      for (int b = G-1; b >= 0; b--) begin
         if (low[b]) begin
            first_bit = GB'(b);
         end
      end
   end

   assign last        = (grp_ff == GW'(NG-1));
   assign status.done = active_ff && (any || last);
   assign status.hit  = active_ff && any;
   assign pos_full    = PSW'({grp_ff, first_bit}) + PSW'(1);
   assign position    = CW'(pos_full);

   always_comb begin
      vec_in    = vec_ff;
      grp_in    = grp_ff;
      active_in = active_ff;
      if (start) begin
         vec_in    = VW'(match_vector);
         grp_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (status.done) begin
            active_in = 1'b0;
         end else begin
            vec_in = vec_ff >> G;
            grp_in = grp_ff + GW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      vec_ff <= vec_in;
      grp_ff <= grp_in;
   end

endmodule

// ----- rtl/positional_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list in a row of cells: insert at position, delete at
// position, search for the first equal entry. One response per request.
// ----------------------------------------------------------------------------
// Timing: insert and delete respond in the cycle after acceptance; a search
// responds once the scanner, which walks the match vector 8 cells per cycle,
// finds a match or has passed the last group of cells without one.
// Throughput: one transaction at a time; next request taken the cycle after
// the response is taken. Reset: synchronous, empties the list.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
   parameter int CAPACITY   = ple_pkg::DEFAULT_CAPACITY,
   parameter int DATA_WIDTH = ple_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);
   localparam int PW = ((CW > 7) ? CW : 7) + 1;

   ple_pkg::state_type       state_ff;
   ple_pkg::state_type       state_in;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   ple_pkg::rsp_type         rsp_ff;
   ple_pkg::rsp_type         rsp_in;
   ple_pkg::cell_cmd_type    cmd;
   ple_pkg::scan_status_type scan_status;
   logic                     scan_start;
   logic [CW-1:0]            scan_pos;
   logic [IW-1:0]            idx;
   logic [PW-1:0]            pos_w;
   logic [PW-1:0]            cnt_w;
   logic [PW-1:0]            pos_m1;
   logic [63:0]              value_ext;
   logic [DATA_WIDTH-1:0]    key;
   logic [DATA_WIDTH-1:0]    cell_data [CAPACITY];
   logic [CAPACITY-1:0]      match_vector;

   assign value_ext = 64'($signed(req_data.value));
   assign key       = value_ext[DATA_WIDTH-1:0];
   assign pos_w     = PW'(req_data.position);
   assign cnt_w     = PW'(count_ff);
   assign pos_m1    = pos_w - PW'(1);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = key;
      end else begin : g_mid
         assign left_data = cell_data[g-1];
      end
      if (g == CAPACITY-1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_inner
         assign right_data = cell_data[g+1];
      end
      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CAPACITY   (CAPACITY),
         .INDEX      (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (idx),
         .count      (count_ff),
         .key        (key),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g]),
         .match      (match_vector[g])
      );
   end

   ple_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .match_vector (match_vector),
      .status       (scan_status),
      .position     (scan_pos)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rsp_in     = rsp_ff;
      cmd        = '0;
      scan_start = 1'b0;
      idx        = IW'(pos_m1);
      unique case (state_ff)
         ple_pkg::STATE_IDLE: begin
            if (req_valid) begin
               rsp_in.found_position = '0;
               rsp_in.length         = 7'(count_ff);
               state_in              = ple_pkg::STATE_RESP;
               case (req_data.opcode)
                  ple_pkg::OP_INSERT: begin
                     idx = (pos_m1 > cnt_w) ? IW'(cnt_w) : IW'(pos_m1);
                     if (req_data.position == '0) begin
                        rsp_in.status = ple_pkg::STATUS_BAD_POS;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        rsp_in.status = ple_pkg::STATUS_FULL;
                     end else begin
                        cmd.insert    = 1'b1;
                        count_in      = count_ff + CW'(1);
                        rsp_in.status = ple_pkg::STATUS_OK;
                        rsp_in.length = 7'(count_in);
                     end
                  end
                  ple_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ple_pkg::STATUS_EMPTY;
                     end else if (req_data.position == '0 || pos_w > cnt_w) begin
                        rsp_in.status = ple_pkg::STATUS_BAD_POS;
                     end else begin
                        cmd.delete    = 1'b1;
                        count_in      = count_ff - CW'(1);
                        rsp_in.status = ple_pkg::STATUS_OK;
                        rsp_in.length = 7'(count_in);
                     end
                  end
                  ple_pkg::OP_SEARCH: begin
                     scan_start = 1'b1;
                     state_in   = ple_pkg::STATE_SCAN;
                  end
                  default: begin
                     rsp_in.status = ple_pkg::STATUS_BAD_POS;
                  end
               endcase
            end
         end
         ple_pkg::STATE_SCAN: begin
            if (scan_status.done) begin
               rsp_in.status = scan_status.hit ? ple_pkg::STATUS_OK
                                               : ple_pkg::STATUS_NOT_FOUND;
               rsp_in.found_position = scan_status.hit ? 7'(scan_pos) : 7'd0;
               rsp_in.length         = 7'(count_ff);
               state_in              = ple_pkg::STATE_RESP;
            end
         end
         ple_pkg::STATE_RESP: begin
            if (!rsp_stall) begin
               state_in = ple_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = ple_pkg::STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::STATE_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ple_pkg::STATE_IDLE);
   assign rsp_valid = (state_ff == ple_pkg::STATE_RESP);
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.opcode == ple_pkg::OP_INSERT &&
       req_data.position != '0 && count_ff != CW'(CAPACITY))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.found_position == '0 ||
                     rsp_data.status == ple_pkg::STATUS_OK))
      else $error("found position on a failed transaction");

   assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> state_ff == ple_pkg::STATE_SCAN)
      else $error("scan finished outside a search");

endmodule
